// File: sv/xdec_pkg.sv
// ----------------------------------------------------------------------------
// xdec_pkg: shared types, codes and opcode tables for the instruction decoder
// Holds the operand and result formats and the opcode classification
// functions used by the byte gatherer and the result formatter.
// ----------------------------------------------------------------------------
package xdec_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h0f;

    // Instruction kinds.
    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_INC  = 3'd1;
    localparam logic [2:0] KIND_JE   = 3'd2;
    localparam logic [2:0] KIND_MOV  = 3'd3;
    localparam logic [2:0] KIND_HLT  = 3'd4;
    localparam logic [2:0] KIND_TEST = 3'd5;

    // Operand addressing modes.
    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_REG    = 3'd1;
    localparam logic [2:0] MODE_IND    = 3'd2;
    localparam logic [2:0] MODE_DIRECT = 3'd3;
    localparam logic [2:0] MODE_DISP8  = 3'd4;
    localparam logic [2:0] MODE_DISP16 = 3'd5;
    localparam logic [2:0] MODE_IMM    = 3'd6;

    // ModRM fields.
    localparam logic [1:0] MOD_NODISP = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [1:0] MOD_REGS   = 2'b11;
    localparam logic [2:0] RM_DIRECT  = 3'b110;

    // Opcodes that are named individually.
    localparam logic [7:0] OP_ADD_AL_IMM = 8'h04;
    localparam logic [7:0] OP_ADD_AX_IMM = 8'h05;
    localparam logic [7:0] OP_JE_REL8    = 8'h74;
    localparam logic [7:0] OP_JE_REL16   = 8'h84;
    localparam logic [7:0] OP_GRP_ADD8   = 8'h80;
    localparam logic [7:0] OP_GRP_ADD16  = 8'h81;
    localparam logic [7:0] OP_GRP_TEST8  = 8'hf6;
    localparam logic [7:0] OP_GRP_TEST16 = 8'hf7;
    localparam logic [7:0] OP_HLT        = 8'hf4;

    typedef struct packed {
        logic        fire;
        logic        status;
        logic        escaped;
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [2:0]  length;
    } instr_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        wide;
        logic [2:0]  reg_num;
        logic [15:0] value;
    } operand_t;

    typedef struct packed {
        logic       status;
        logic [2:0] kind;
        logic [2:0] length;
        operand_t   dst;
        operand_t   src;
    } result_t;

    function automatic logic is_group(input logic [7:0] op);
        return op == OP_GRP_ADD8 || op == OP_GRP_ADD16 ||
               op == OP_GRP_TEST8 || op == OP_GRP_TEST16;
    endfunction

    function automatic logic needs_modrm(input logic esc, input logic [7:0] op);
        return !esc && (op <= 8'h03 || is_group(op) || (op >= 8'h88 && op <= 8'h8b));
    endfunction

    function automatic logic [1:0] imm_len(input logic esc, input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (!esc) begin
            if (op == OP_ADD_AL_IMM || op == OP_GRP_ADD8 || op == OP_GRP_TEST8 ||
                (op >= 8'hb0 && op <= 8'hb7)) begin
                n = 2'd1;
            end else if (op == OP_ADD_AX_IMM || op == OP_GRP_ADD16 || op == OP_GRP_TEST16 ||
                         (op >= 8'hb8 && op <= 8'hbf)) begin
                n = 2'd2;
            end
        end
        return n;
    endfunction

    function automatic logic [1:0] disp_len(input logic esc, input logic [7:0] op,
                                            input logic [7:0] modrm);
        logic [1:0] n;
        n = 2'd0;
        if (esc) begin
            n = (op == OP_JE_REL16) ? 2'd2 : 2'd0;
        end else if (op == OP_JE_REL8) begin
            n = 2'd1;
        end else if (needs_modrm(esc, op)) begin
            if (modrm[7:6] == MOD_DISP8) begin
                n = 2'd1;
            end else if (modrm[7:6] == MOD_DISP16) begin
                n = 2'd2;
            end else if (modrm[7:6] == MOD_NODISP && modrm[2:0] == RM_DIRECT) begin
                n = 2'd2;
            end
        end
        return n;
    endfunction

    function automatic logic op_known(input logic esc, input logic [7:0] op);
        if (esc) begin
            return op == OP_JE_REL16;
        end
        return needs_modrm(esc, op) || op == OP_ADD_AL_IMM || op == OP_ADD_AX_IMM ||
               (op >= 8'h40 && op <= 8'h47) || op == OP_JE_REL8 ||
               (op >= 8'hb0 && op <= 8'hbf) || op == OP_HLT;
    endfunction

    function automatic logic [2:0] kind_of(input logic esc, input logic [7:0] op);
        logic [2:0] k;
        k = KIND_ADD;
        if (esc || op == OP_JE_REL8) begin
            k = KIND_JE;
        end else if (op >= 8'h40 && op <= 8'h47) begin
            k = KIND_INC;
        end else if ((op >= 8'h88 && op <= 8'h8b) || (op >= 8'hb0 && op <= 8'hbf)) begin
            k = KIND_MOV;
        end else if (op == OP_HLT) begin
            k = KIND_HLT;
        end else if (op == OP_GRP_TEST8 || op == OP_GRP_TEST16) begin
            k = KIND_TEST;
        end
        return k;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

endpackage

// File: sv/xdec_fsm.sv
// ----------------------------------------------------------------------------
// xdec_fsm: byte gatherer
// Walks the escape, opcode, ModRM, displacement and immediate bytes of one
// instruction and flags the byte that completes it or hits an unknown opcode.
// ----------------------------------------------------------------------------
module xdec_fsm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       code_byte,
    output xdec_pkg::instr_t instr
);

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_ESCOP = 3'd1;
    localparam logic [2:0] PH_MODRM = 3'd2;
    localparam logic [2:0] PH_DISP  = 3'd3;
    localparam logic [2:0] PH_IMM   = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    logic [1:0]  left_reg, left_next;
    logic [2:0]  count_reg, count_next;

    logic       take;
    logic       advance;
    logic [1:0] from;
    logic       fire;
    logic       err;
    logic [1:0] total;
    logic       pos;
    logic [1:0] dlen;
    logic [1:0] ilen;

    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        op_next    = op_reg;
        modrm_next = modrm_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        left_next  = left_reg;
        count_next = count_reg;
        take       = 1'b0;
        advance    = 1'b0;
        from       = 2'd0;
        fire       = 1'b0;
        err        = 1'b0;
        total      = 2'd0;
        pos        = 1'b0;
        dlen       = 2'd0;
        ilen       = 2'd0;

        if (accept) begin
            unique case (phase_reg)
                PH_ESCOP: begin
                    count_next = 3'd2;
                    take       = 1'b1;
                end
                PH_MODRM: begin
                    modrm_next = code_byte;
                    count_next = count_reg + 3'd1;
                    advance    = 1'b1;
                    from       = 2'd1;
                end
                PH_DISP: begin
                    count_next = count_reg + 3'd1;
                    total      = xdec_pkg::disp_len(esc_reg, op_reg, modrm_reg);
                    // Low bit of (total - left) picks the byte lane.
                    pos        = total[0] ^ left_reg[0];
                    disp_next  = disp_reg | (pos ? {code_byte, 8'h00} : {8'h00, code_byte});
                    if (left_reg != 2'd0) begin
                        left_next = left_reg - 2'd1;
                    end
                    if (left_next == 2'd0) begin
                        advance = 1'b1;
                        from    = 2'd2;
                    end
                end
                PH_IMM: begin
                    count_next = count_reg + 3'd1;
                    total      = xdec_pkg::imm_len(esc_reg, op_reg);
                    pos        = total[0] ^ left_reg[0];
                    imm_next   = imm_reg | (pos ? {code_byte, 8'h00} : {8'h00, code_byte});
                    if (left_reg != 2'd0) begin
                        left_next = left_reg - 2'd1;
                    end
                    if (left_next == 2'd0) begin
                        fire = 1'b1;
                    end
                end
                default: begin
                    count_next = 3'd1;
                    esc_next   = 1'b0;
                    if (code_byte == xdec_pkg::ESC_BYTE) begin
                        esc_next   = 1'b1;
                        phase_next = PH_ESCOP;
                    end else begin
                        take = 1'b1;
                    end
                end
            endcase
        end

        if (take) begin
            op_next    = code_byte;
            modrm_next = 8'h00;
            disp_next  = 16'h0000;
            imm_next   = 16'h0000;
            if (!xdec_pkg::op_known(esc_next, code_byte)) begin
                fire = 1'b1;
                err  = 1'b1;
            end else begin
                advance = 1'b1;
                from    = 2'd0;
            end
        end

        if (advance) begin
            dlen = xdec_pkg::disp_len(esc_next, op_next, modrm_next);
            ilen = xdec_pkg::imm_len(esc_next, op_next);
            if (from == 2'd0 && xdec_pkg::needs_modrm(esc_next, op_next)) begin
                phase_next = PH_MODRM;
            end else if (from != 2'd2 && dlen != 2'd0) begin
                phase_next = PH_DISP;
                left_next  = dlen;
            end else if (ilen != 2'd0) begin
                phase_next = PH_IMM;
                left_next  = ilen;
            end else begin
                fire = 1'b1;
            end
        end

        instr.fire    = fire;
        instr.status  = err;
        instr.escaped = esc_next;
        instr.opcode  = op_next;
        instr.modrm   = modrm_next;
        instr.disp    = disp_next;
        instr.imm     = imm_next;
        instr.length  = count_next;

        if (fire) begin
            phase_next = PH_FIRST;
            esc_next   = 1'b0;
            left_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            esc_reg   <= 1'b0;
            op_reg    <= 8'h00;
            modrm_reg <= 8'h00;
            disp_reg  <= 16'h0000;
            imm_reg   <= 16'h0000;
            left_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            op_reg    <= op_next;
            modrm_reg <= modrm_next;
            disp_reg  <= disp_next;
            imm_reg   <= imm_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/xdec_format.sv
// ----------------------------------------------------------------------------
// xdec_format: result formatter
// Turns a completed instruction into its kind, length and the destination
// and source operand descriptors.
// ----------------------------------------------------------------------------
module xdec_format (
    input  xdec_pkg::instr_t  instr,
    output xdec_pkg::result_t res
);

    function automatic xdec_pkg::operand_t reg_operand(input logic wide, input logic [2:0] r);
        xdec_pkg::operand_t o;
        o.mode    = xdec_pkg::MODE_REG;
        o.wide    = wide;
        o.reg_num = r;
        o.value   = 16'h0000;
        return o;
    endfunction

    function automatic xdec_pkg::operand_t imm_operand(input logic wide,
                                                       input logic [15:0] imm);
        xdec_pkg::operand_t o;
        o.mode    = xdec_pkg::MODE_IMM;
        o.wide    = wide;
        o.reg_num = 3'd0;
        o.value   = wide ? imm : {8'h00, imm[7:0]};
        return o;
    endfunction

    function automatic xdec_pkg::operand_t mem_operand(input logic wide,
                                                       input logic [7:0] modrm,
                                                       input logic [15:0] disp);
        xdec_pkg::operand_t o;
        o.wide    = wide;
        o.reg_num = modrm[2:0];
        o.value   = 16'h0000;
        if (modrm[7:6] == xdec_pkg::MOD_REGS) begin
            o.mode = xdec_pkg::MODE_REG;
        end else if (modrm[7:6] == xdec_pkg::MOD_DISP8) begin
            o.mode  = xdec_pkg::MODE_DISP8;
            o.value = xdec_pkg::sext8(disp[7:0]);
        end else if (modrm[7:6] == xdec_pkg::MOD_DISP16) begin
            o.mode  = xdec_pkg::MODE_DISP16;
            o.value = disp;
        end else if (modrm[2:0] == xdec_pkg::RM_DIRECT) begin
            o.mode    = xdec_pkg::MODE_DIRECT;
            o.reg_num = 3'd0;
            o.value   = disp;
        end else begin
            o.mode = xdec_pkg::MODE_IND;
        end
        return o;
    endfunction

    logic [7:0] op;
    logic       w;

    assign op = instr.opcode;
    assign w  = instr.opcode[0];

    always_comb begin
        res        = '0;
        res.status = instr.status;
        res.length = instr.length;
        if (!instr.status) begin
            res.kind = xdec_pkg::kind_of(instr.escaped, op);
            if (instr.escaped) begin
                res.dst.mode  = xdec_pkg::MODE_DISP16;
                res.dst.wide  = 1'b1;
                res.dst.value = instr.disp;
            end else if (xdec_pkg::needs_modrm(1'b0, op)) begin
                if (xdec_pkg::is_group(op)) begin
                    res.dst = mem_operand(w, instr.modrm, instr.disp);
                    res.src = imm_operand(w, instr.imm);
                end else if (op[1]) begin
                    // Direction bit set: the ModRM reg field is the destination.
                    res.dst = reg_operand(w, instr.modrm[5:3]);
                    res.src = mem_operand(w, instr.modrm, instr.disp);
                end else begin
                    res.dst = mem_operand(w, instr.modrm, instr.disp);
                    res.src = reg_operand(w, instr.modrm[5:3]);
                end
            end else if (op == xdec_pkg::OP_ADD_AL_IMM || op == xdec_pkg::OP_ADD_AX_IMM) begin
                res.dst = reg_operand(w, 3'd0);
                res.src = imm_operand(w, instr.imm);
            end else if (op >= 8'h40 && op <= 8'h47) begin
                res.dst = reg_operand(1'b1, op[2:0]);
            end else if (op == xdec_pkg::OP_JE_REL8) begin
                res.dst.mode  = xdec_pkg::MODE_DISP8;
                res.dst.value = xdec_pkg::sext8(instr.disp[7:0]);
            end else if (op >= 8'hb0 && op <= 8'hbf) begin
                res.dst = reg_operand(op[3], op[2:0]);
                res.src = imm_operand(op[3], instr.imm);
            end
        end
    end

endmodule

// File: sv/x86_subset_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// x86_subset_instruction_decoder_unit: byte-serial decoder for an 8086 subset
//
// The input channel (s_valid, s_ready, s_code_byte) carries the code stream,
// one byte per word. The result channel (m_valid, m_ready, m_*) carries one
// decoded instruction per word: status, kind, length and a destination and
// source descriptor. A result word is produced for the byte that completes an
// instruction, and at once for an unknown opcode (status 1).
// The result is registered and presented on the cycle after its last byte is
// accepted. The input takes one code byte per cycle while s_ready is high.
// s_ready stays high while the result register is empty or being drained,
// so a stalled receiver holds back the input by one word of buffering.
// Reset (aresetn low, synchronous) empties the result register and puts the
// decoder back to expecting the first byte of an instruction.
// ----------------------------------------------------------------------------
module x86_subset_instruction_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_code_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [2:0]  m_kind,
    output logic [2:0]  m_length,
    output logic [2:0]  m_dst_mode,
    output logic        m_dst_wide,
    output logic [2:0]  m_dst_reg,
    output logic [15:0] m_dst_value,
    output logic [2:0]  m_src_mode,
    output logic        m_src_wide,
    output logic [2:0]  m_src_reg,
    output logic [15:0] m_src_value
);

    logic              accept;
    xdec_pkg::instr_t  instr;
    xdec_pkg::result_t res;
    xdec_pkg::result_t res_reg;
    logic              m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    xdec_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .code_byte (s_code_byte),
        .instr     (instr)
    );

    xdec_format u_format (
        .instr (instr),
        .res   (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && instr.fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && instr.fire) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = res_reg.status;
    assign m_kind      = res_reg.kind;
    assign m_length    = res_reg.length;
    assign m_dst_mode  = res_reg.dst.mode;
    assign m_dst_wide  = res_reg.dst.wide;
    assign m_dst_reg   = res_reg.dst.reg_num;
    assign m_dst_value = res_reg.dst.value;
    assign m_src_mode  = res_reg.src.mode;
    assign m_src_wide  = res_reg.src.wide;
    assign m_src_reg   = res_reg.src.reg_num;
    assign m_src_value = res_reg.src.value;

endmodule

// File: sv/xdec_checker.sv
// ----------------------------------------------------------------------------
// xdec_checker: port-level checks for the instruction decoder
// Watches the top-level ports for result stability, reset behavior and the
// shape of error and halt results.
// ----------------------------------------------------------------------------
module xdec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_code_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_status,
    input logic [2:0]  m_kind,
    input logic [2:0]  m_length,
    input logic [2:0]  m_dst_mode,
    input logic        m_dst_wide,
    input logic [2:0]  m_dst_reg,
    input logic [15:0] m_dst_value,
    input logic [2:0]  m_src_mode,
    input logic        m_src_wide,
    input logic [2:0]  m_src_reg,
    input logic [15:0] m_src_value
);

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_kind) &&
        $stable(m_length) && $stable(m_dst_value) && $stable(m_src_value))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An unknown opcode reports only its length, one or two bytes.
    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_kind == xdec_pkg::KIND_ADD &&
        m_dst_mode == xdec_pkg::MODE_NONE && m_src_mode == xdec_pkg::MODE_NONE &&
        (m_length == 3'd1 || m_length == 3'd2))
        else $error("malformed error result");

    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status && m_kind == xdec_pkg::KIND_HLT |->
        m_length == 3'd1 && m_dst_mode == xdec_pkg::MODE_NONE &&
        m_src_mode == xdec_pkg::MODE_NONE)
        else $error("malformed halt result");

    // The input may only stall while a result word waits.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a pending result");

endmodule

bind x86_subset_instruction_decoder_unit xdec_checker u_xdec_checker (.*);
